@@ hw/rtl/mltd_pkg.sv @@
// package for the marker/length/type deframer
// holds phase codes, result kinds, register indices, reset values and the result and config records; no dependencies
`default_nettype none

package mltd_pkg;

    localparam int PhaseWidth = 2;
    localparam logic [PhaseWidth-1:0] PH_HUNT = 2'd0;
    localparam logic [PhaseWidth-1:0] PH_SIZE = 2'd1;
    localparam logic [PhaseWidth-1:0] PH_TYPE = 2'd2;
    localparam logic [PhaseWidth-1:0] PH_DATA = 2'd3;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam int AddrWidth = 3;
    localparam logic REG_MARKER = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic [7:0] MARKER_RESET = 8'd165;
    localparam logic [7:0] LIMIT_RESET  = 8'd64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_type;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
        logic       last;
        logic       synced;
    } result_t;

    typedef struct packed {
        logic [7:0] marker_value;
        logic [7:0] payload_limit;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mltd_cfg.sv @@
// apb configuration registers of the deframer: marker value and payload limit
// depends on mltd_pkg
`default_nettype none

module mltd_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mltd_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output mltd_pkg::cfg_t                      cfg
);

    mltd_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker_value  <= mltd_pkg::MARKER_RESET;
            cfg_reg.payload_limit <= mltd_pkg::LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                mltd_pkg::REG_MARKER: cfg_reg.marker_value  <= pwdata[7:0];
                mltd_pkg::REG_LIMIT:  cfg_reg.payload_limit <= pwdata[7:0];
                default:              cfg_reg.marker_value  <= cfg_reg.marker_value;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mltd_pkg::REG_MARKER: prdata = {24'd0, cfg_reg.marker_value};
            mltd_pkg::REG_LIMIT:  prdata = {24'd0, cfg_reg.payload_limit};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/marker_length_type_deframer.sv @@
// top level of the marker/length/type deframer: input register, parser state, result register
// depends on mltd_pkg and mltd_cfg
`default_nettype none

// Streaming frame parser: one received byte per transaction, frames laid out as marker, size
// (payload length plus one), type, payload. Each byte gives at most one result: a header, a
// payload byte, or a framing error; frames of type zero that pass the size checks are consumed
// with no results. A byte is taken into an input register and parsed from there into the
// result register, with the parser state update between those two registers; the block takes
// one byte every cycle while result_stall does not hold a full result register. Bytes that
// give no result still pass the parse stage. Registers: marker_value at byte address 0,
// payload_limit at 4; write them only while the block is idle.
module marker_length_type_deframer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mltd_pkg::AddrWidth-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    input  wire logic                           byte_valid,
    output logic                                byte_stall,
    input  wire logic [7:0]                     in_byte,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [1:0]                     kind,
    output logic      [7:0]                     frame_type,
    output logic      [7:0]                     payload_len,
    output logic      [7:0]                     data_byte,
    output logic                                last,
    output logic                                synced
);

    mltd_pkg::cfg_t    cfg;
    logic              byte_valid_reg;
    logic [7:0]        byte_reg;
    logic              advance;

    logic [mltd_pkg::PhaseWidth-1:0] phase_reg, phase_next;
    logic [7:0]        bytes_left_reg, bytes_left_next;
    logic [7:0]        held_size_reg, held_size_next;
    logic [7:0]        held_type_reg, held_type_next;
    logic              lock_reg, lock_next;
    logic              discard_reg, discard_next;
    logic [7:0]        plen;
    logic [7:0]        left_dec;
    logic              emit;
    mltd_pkg::result_t res;
    mltd_pkg::result_t result_reg;
    logic              result_valid_reg;

    mltd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parse stage moves when the result register is free or being emptied
    assign advance    = !result_valid_reg || !result_stall;
    assign byte_stall = byte_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            byte_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign plen = held_size_reg - 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        held_size_next  = held_size_reg;
        held_type_next  = held_type_reg;
        lock_next       = lock_reg;
        discard_next    = discard_reg;
        left_dec        = bytes_left_reg;
        emit            = 1'b0;
        res             = '0;
        unique case (phase_reg)
            mltd_pkg::PH_HUNT:
            begin
                if (byte_reg == cfg.marker_value)
                begin
                    lock_next  = 1'b1;
                    phase_next = mltd_pkg::PH_SIZE;
                end
                else
                begin
                    lock_next = 1'b0;
                end
            end
            mltd_pkg::PH_SIZE:
            begin
                held_size_next = byte_reg;
                phase_next     = mltd_pkg::PH_TYPE;
            end
            mltd_pkg::PH_TYPE:
            begin
                held_type_next = byte_reg;
                res.frame_type = byte_reg;
                if (held_size_reg == 8'd0 || plen >= cfg.payload_limit)
                begin
                    lock_next       = 1'b0;
                    phase_next      = mltd_pkg::PH_HUNT;
                    emit            = 1'b1;
                    res.kind        = mltd_pkg::KIND_ERROR;
                    res.payload_len = (held_size_reg == 8'd0) ? 8'd0 : plen;
                    res.last        = 1'b1;
                end
                else
                begin
                    bytes_left_next = plen;
                    phase_next      = (plen == 8'd0) ? mltd_pkg::PH_HUNT : mltd_pkg::PH_DATA;
                    discard_next    = (byte_reg == 8'd0) && (plen != 8'd0);
                    emit            = (byte_reg != 8'd0);
                    res.kind        = mltd_pkg::KIND_HEADER;
                    res.payload_len = plen;
                    res.last        = (plen == 8'd0);
                end
            end
            mltd_pkg::PH_DATA:
            begin
                if (bytes_left_reg != 8'd0)
                begin
                    left_dec = bytes_left_reg - 8'd1;
                end
                bytes_left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    phase_next = mltd_pkg::PH_HUNT;
                end
                if (discard_reg)
                begin
                    if (left_dec == 8'd0)
                    begin
                        discard_next = 1'b0;
                    end
                end
                else
                begin
                    emit            = 1'b1;
                    res.kind        = mltd_pkg::KIND_DATA;
                    res.frame_type  = held_type_reg;
                    res.payload_len = plen;
                    res.data_byte   = byte_reg;
                    res.last        = (left_dec == 8'd0);
                end
            end
            default:
            begin
                phase_next = mltd_pkg::PH_HUNT;
            end
        endcase
        res.synced = lock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mltd_pkg::PH_HUNT;
            bytes_left_reg <= 8'd0;
            held_size_reg  <= 8'd0;
            held_type_reg  <= 8'd0;
            lock_reg       <= 1'b0;
            discard_reg    <= 1'b0;
        end
        else if (byte_valid_reg && advance)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            held_size_reg  <= held_size_next;
            held_type_reg  <= held_type_next;
            lock_reg       <= lock_next;
            discard_reg    <= discard_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= byte_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && byte_valid_reg && emit)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = result_reg.kind;
    assign frame_type   = result_reg.frame_type;
    assign payload_len  = result_reg.payload_len;
    assign data_byte    = result_reg.data_byte;
    assign last         = result_reg.last;
    assign synced       = result_reg.synced;

`ifndef SYNTHESIS
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> kind <= mltd_pkg::KIND_ERROR)
        else $error("result kind out of range");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == mltd_pkg::KIND_ERROR |-> last && !synced && data_byte == 8'd0)
        else $error("framing error result malformed");

    a_locked_results: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != mltd_pkg::KIND_ERROR |-> synced)
        else $error("header or payload result while not synced");

    a_hunt_no_discard: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mltd_pkg::PH_HUNT |-> !discard_reg)
        else $error("discard flag left set while hunting");
`endif

endmodule

`default_nettype wire

@@ test/tb_marker_length_type_deframer.sv @@
// testbench for marker_length_type_deframer: directed table plus random frame streams
// checks results against a parser model or typed rows; depends on mltd_pkg and the rtl
`default_nettype none

module tb_marker_length_type_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                CYCLE_LIMIT = 200000;
    localparam int                SETTLE      = 4;
    localparam int                PHASE_BYTES = 235;
    localparam int                NUM_PHASES  = 8;
    localparam mltd_pkg::result_t NO_RES      = '0;

    typedef struct packed {
        logic [7:0]        in_val;
        logic              typed;
        mltd_pkg::result_t want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [25] = '{
        '{8'h00, 1'b0, NO_RES},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h37, 1'b1, '{mltd_pkg::KIND_ERROR, 8'h37, 8'd0, 8'd0, 1'b1, 1'b0}},
        '{8'hA5, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b1, '{mltd_pkg::KIND_ERROR, 8'hFF, 8'd254, 8'd0, 1'b1, 1'b0}},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h41, 1'b0, NO_RES},
        '{8'h01, 1'b1, '{mltd_pkg::KIND_ERROR, 8'h01, 8'd64, 8'd0, 1'b1, 1'b0}},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h80, 1'b1, '{mltd_pkg::KIND_HEADER, 8'h80, 8'd0, 8'd0, 1'b1, 1'b1}},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h12, 1'b0, NO_RES},
        '{8'h34, 1'b0, NO_RES},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h04, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h5A, 1'b0, NO_RES}
    };

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           psel         = 1'b0;
    logic                           penable      = 1'b0;
    logic                           pwrite       = 1'b0;
    logic [mltd_pkg::AddrWidth-1:0] paddr        = '0;
    logic [31:0]                    pwdata       = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           byte_valid   = 1'b0;
    logic                           byte_stall;
    logic [7:0]                     in_byte      = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [1:0]                     kind;
    logic [7:0]                     frame_type;
    logic [7:0]                     payload_len;
    logic [7:0]                     data_byte;
    logic                           last;
    logic                           synced;

    // parser model state and register copies
    logic [1:0] ph;
    logic [7:0] left_cnt;
    logic [7:0] size_q;
    logic [7:0] type_q;
    logic       locked;
    logic       dropping;
    logic [7:0] cfg_marker;
    logic [7:0] cfg_limit;

    mltd_pkg::result_t due_results [$];
    bit          quiet_stretch = 1'b0;
    int          stall_run     = 0;
    int          cycle_cnt     = 0;
    int          mismatches    = 0;
    int          results_seen  = 0;
    int          bytes_sent    = 0;
    int          frame_bytes   = 0;

    marker_length_type_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .frame_type   (frame_type),
        .payload_len  (payload_len),
        .data_byte    (data_byte),
        .last         (last),
        .synced       (synced)
    );

    always #5 clk = ~clk;

    function automatic string fmt_result(input mltd_pkg::result_t r);
        return $sformatf("kind %0d type %02h len %0d data %02h last %0d synced %0d",
                         r.kind, r.frame_type, r.payload_len, r.data_byte, r.last, r.synced);
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output mltd_pkg::result_t r);
        logic [7:0] plen;
        plen = size_q - 8'd1;
        r = '0;
        case (ph)
            mltd_pkg::PH_HUNT:
            begin
                locked = (b == cfg_marker);
                if (locked)
                begin
                    ph = mltd_pkg::PH_SIZE;
                end
                return 1'b0;
            end
            mltd_pkg::PH_SIZE:
            begin
                size_q = b;
                ph = mltd_pkg::PH_TYPE;
                return 1'b0;
            end
            mltd_pkg::PH_TYPE:
            begin
                type_q = b;
                if (size_q == 8'd0 || plen >= cfg_limit)
                begin
                    locked = 1'b0;
                    ph = mltd_pkg::PH_HUNT;
                    r.kind = mltd_pkg::KIND_ERROR;
                    r.frame_type = b;
                    r.payload_len = (size_q == 8'd0) ? 8'd0 : plen;
                    r.last = 1'b1;
                    r.synced = 1'b0;
                    return 1'b1;
                end
                left_cnt = plen;
                dropping = (b == 8'd0);
                ph = (plen == 8'd0) ? mltd_pkg::PH_HUNT : mltd_pkg::PH_DATA;
                if (dropping)
                begin
                    if (plen == 8'd0)
                    begin
                        dropping = 1'b0;
                    end
                    return 1'b0;
                end
                r.kind = mltd_pkg::KIND_HEADER;
                r.frame_type = b;
                r.payload_len = plen;
                r.last = (plen == 8'd0);
                r.synced = locked;
                return 1'b1;
            end
            default:
            begin
                if (left_cnt != 8'd0)
                begin
                    left_cnt = left_cnt - 8'd1;
                end
                if (left_cnt == 8'd0)
                begin
                    ph = mltd_pkg::PH_HUNT;
                end
                if (dropping)
                begin
                    if (left_cnt == 8'd0)
                    begin
                        dropping = 1'b0;
                    end
                    return 1'b0;
                end
                r.kind = mltd_pkg::KIND_DATA;
                r.frame_type = type_q;
                r.payload_len = plen;
                r.data_byte = b;
                r.last = (left_cnt == 8'd0);
                r.synced = locked;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input mltd_pkg::result_t want);
        mltd_pkg::result_t r;
        bit                got;
        if (!quiet_stretch && $urandom_range(99) < 3)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= b;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        got = parse_byte(b, r);
        bytes_sent++;
        if (typed)
        begin
            due_results.push_back(want);
        end
        else if (got)
        begin
            due_results.push_back(r);
        end
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mltd_pkg::REG_MARKER)
        begin
            cfg_marker = val;
        end
        else
        begin
            cfg_limit = val;
        end
    endtask

    task automatic send_frame();
        int unsigned pick;
        int unsigned plen;
        int unsigned top;
        logic [7:0]  size_b;
        logic [7:0]  ftype;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            b = 8'($urandom_range(255));
            if (b == cfg_marker)
            begin
                b = ~b;
            end
            send_byte(b, 1'b0, NO_RES);
            return;
        end
        if (pick < 20 || cfg_limit == 8'd0)
        begin
            if (cfg_limit == 8'd255 || $urandom_range(1) == 0)
            begin
                size_b = 8'd0;
            end
            else
            begin
                size_b = 8'($urandom_range(254, cfg_limit) + 1);
            end
            send_byte(cfg_marker, 1'b0, NO_RES);
            send_byte(size_b, 1'b0, NO_RES);
            send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
            frame_bytes += 3;
            return;
        end
        top = cfg_limit - 1;
        if ($urandom_range(9) == 0)
        begin
            plen = $urandom_range(top);
        end
        else
        begin
            plen = $urandom_range((top < 10) ? top : 10);
        end
        ftype = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255));
        send_byte(cfg_marker, 1'b0, NO_RES);
        send_byte(8'(plen + 1), 1'b0, NO_RES);
        send_byte(ftype, 1'b0, NO_RES);
        for (int i = 0; i < plen; i++)
        begin
            b = ($urandom_range(99) < 20) ? cfg_marker : 8'($urandom_range(255));
            send_byte(b, 1'b0, NO_RES);
        end
        frame_bytes += 3 + plen;
    endtask

    // result side: check and random stall
    always @(posedge clk)
    begin
        mltd_pkg::result_t act;
        mltd_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            act = {kind, frame_type, payload_len, data_byte, last, synced};
            results_seen++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result at cycle %0d: %s", cycle_cnt, fmt_result(act));
                end
            end
            else
            begin
                want = due_results.pop_front();
                if (act.kind !== want.kind || act.frame_type !== want.frame_type ||
                    act.payload_len !== want.payload_len || act.data_byte !== want.data_byte ||
                    act.last !== want.last || act.synced !== want.synced)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d: expected %s, got %s", cycle_cnt,
                                 fmt_result(want), fmt_result(act));
                    end
                end
            end
        end
        if (stall_run > 0)
        begin
            stall_run    <= stall_run - 1;
            result_stall <= 1'b1;
        end
        else if (!quiet_stretch && $urandom_range(99) < 3)
        begin
            stall_run    <= $urandom_range(3);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     due_results.size());
            $display("** marker_length_type_deframer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] marker_set [NUM_PHASES];
        logic [7:0] limit_set  [NUM_PHASES];
        marker_set = '{8'h5A, 8'h00, 8'hFF, 8'($urandom_range(255)), 8'hA5,
                       8'($urandom_range(255)), 8'h7E, mltd_pkg::MARKER_RESET};
        limit_set  = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(255, 1)), 8'd16,
                       8'($urandom_range(255, 1)), 8'd255, mltd_pkg::LIMIT_RESET};
        ph         = mltd_pkg::PH_HUNT;
        left_cnt   = '0;
        size_q     = '0;
        type_q     = '0;
        locked     = 1'b0;
        dropping   = 1'b0;
        cfg_marker = mltd_pkg::MARKER_RESET;
        cfg_limit  = mltd_pkg::LIMIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            send_byte(DIR_ROWS[i].in_val, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            reg_write(mltd_pkg::REG_MARKER, marker_set[p]);
            reg_write(mltd_pkg::REG_LIMIT, limit_set[p]);
            quiet_stretch = (p == 3);
            frame_bytes = 0;
            while (frame_bytes < PHASE_BYTES) send_frame();
            drain();
        end
        quiet_stretch = 1'b0;
        repeat (8) @(posedge clk);

        mismatches += due_results.size();
        $display("sent %0d bytes over %0d register settings, checked %0d results",
                 bytes_sent, NUM_PHASES + 1, results_seen);
        if (mismatches == 0)
        begin
            $display("** marker_length_type_deframer: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("** marker_length_type_deframer: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ marker_length_type_deframer.f @@
hw/rtl/mltd_pkg.sv
hw/rtl/mltd_cfg.sv
hw/rtl/marker_length_type_deframer.sv
test/tb_marker_length_type_deframer.sv
